[hw/rtl/fdi_pkg.sv]
// ----------------------------------------------------------------------------
// fdi_pkg: shared definitions for the decimating FIR
// Sample and coefficient widths, the lowpass coefficient table and the
// control group that the sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package fdi_pkg;

  // Audio samples are Q15, coefficients signed Q1.17.
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int FRAC_SHIFT = 18;
  localparam int ROM_TAPS   = 97;
  localparam int IDX_W      = 8;

  // Defaults for the top-level parameters.
  localparam int TAP_COUNT_DEF  = 97;
  localparam int DECIMATION_DEF = 6;

  // Lowpass coefficients, rounded half away from zero.
  localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_TAPS] = '{
    18'sd0,     18'sd0,     18'sd1,     18'sd3,     18'sd4,
    18'sd3,    -18'sd2,    -18'sd12,   -18'sd24,   -18'sd37,
   -18'sd45,   -18'sd42,   -18'sd24,    18'sd12,    18'sd63,
    18'sd120,   18'sd169,   18'sd191,   18'sd169,   18'sd94,
   -18'sd34,   -18'sd201,  -18'sd373,  -18'sd510,  -18'sd562,
   -18'sd491,  -18'sd277,   18'sd69,    18'sd501,   18'sd936,
    18'sd1270,  18'sd1394,  18'sd1221,  18'sd710,  -18'sd110,
   -18'sd1132, -18'sd2176, -18'sd3007, -18'sd3375, -18'sd3054,
   -18'sd1894,  18'sd143,   18'sd2963,  18'sd6335,  18'sd9920,
    18'sd13312, 18'sd16100, 18'sd17931, 18'sd18570, 18'sd17931,
    18'sd16100, 18'sd13312, 18'sd9920,  18'sd6335,  18'sd2963,
    18'sd143,  -18'sd1894, -18'sd3054, -18'sd3375, -18'sd3007,
   -18'sd2176, -18'sd1132, -18'sd110,   18'sd710,   18'sd1221,
    18'sd1394,  18'sd1270,  18'sd936,   18'sd501,   18'sd69,
   -18'sd277,  -18'sd491,  -18'sd562,  -18'sd510,  -18'sd373,
   -18'sd201,  -18'sd34,    18'sd94,    18'sd169,   18'sd191,
    18'sd169,   18'sd120,   18'sd63,    18'sd12,   -18'sd24,
   -18'sd42,   -18'sd45,   -18'sd37,   -18'sd24,   -18'sd12,
   -18'sd2,     18'sd3,     18'sd4,     18'sd3,     18'sd1,
    18'sd0,     18'sd0
  };

  // Coefficient for one tap; taps past the end of the table weigh zero.
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (idx < IDX_W'(ROM_TAPS)) begin
      c = COEF_ROM[idx[6:0]];
    end
    return c;
  endfunction

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;   // start a new sum
    logic mul_en;  // a valid sample and coefficient pair is presented
  } mac_ctrl_t;

endpackage

[hw/rtl/fdi_in_if.sv]
// ----------------------------------------------------------------------------
// fdi_in_if: input sample channel
// Valid/ready channel carrying one 48 kHz Q15 sample per item.
// ----------------------------------------------------------------------------
interface fdi_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fdi_pkg::SAMPLE_W-1:0]  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

[hw/rtl/fdi_out_if.sv]
// ----------------------------------------------------------------------------
// fdi_out_if: output sample channel
// Valid/ready channel carrying one filtered or bypassed int16 sample per item.
// ----------------------------------------------------------------------------
interface fdi_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fdi_pkg::SAMPLE_W-1:0]  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

[hw/rtl/fdi_cell.sv]
// ----------------------------------------------------------------------------
// fdi_cell: one delay-line cell
// Holds one past sample and takes its neighbour's value when the chain moves.
// ----------------------------------------------------------------------------
module fdi_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic signed [fdi_pkg::SAMPLE_W-1:0] d_i,
  output logic signed [fdi_pkg::SAMPLE_W-1:0] q_o
);

  logic signed [fdi_pkg::SAMPLE_W-1:0] sample_q;

  // The delay line starts out silent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (en_i) begin
      sample_q <= d_i;
    end
  end

  assign q_o = sample_q;

endmodule

[hw/rtl/fdi_mac.sv]
// ----------------------------------------------------------------------------
// fdi_mac: multiply-accumulate and output scaling
// One registered 16x18 multiplier feeding an accumulator, followed by the
// halving, truncation toward zero and int16 saturation of the finished sum.
// ----------------------------------------------------------------------------
module fdi_mac #(
  parameter int TAP_COUNT = fdi_pkg::TAP_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fdi_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [fdi_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [fdi_pkg::COEF_W-1:0]   coef_i,
  output logic signed [fdi_pkg::SAMPLE_W-1:0] result_o
);

  localparam int PROD_W = fdi_pkg::SAMPLE_W + fdi_pkg::COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);
  localparam int Q_W    = ACC_W - fdi_pkg::FRAC_SHIFT;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'((2 ** fdi_pkg::FRAC_SHIFT) - 1);
  localparam logic signed [Q_W-1:0]   MAX_Q      = Q_W'(32767);
  localparam logic signed [Q_W-1:0]   MIN_Q      = -Q_W'(32768);
  localparam logic signed [fdi_pkg::SAMPLE_W-1:0] MAX_OUT = 16'sh7fff;
  localparam logic signed [fdi_pkg::SAMPLE_W-1:0] MIN_OUT = 16'sh8000;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  biased;
  logic signed [Q_W-1:0]    scaled;

  // Product register, then accumulation in the cycle after.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= sample_i * coef_i;
    end
  end

  // Divide by 2^18 rounding toward zero, then clip to int16.
  always_comb begin
    biased = acc_q + (acc_q[ACC_W-1] ? ROUND_BIAS : '0);
    scaled = biased[ACC_W-1:fdi_pkg::FRAC_SHIFT];
    if (scaled > MAX_Q) begin
      result_o = MAX_OUT;
    end else if (scaled < MIN_Q) begin
      result_o = MIN_OUT;
    end else begin
      result_o = scaled[fdi_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

[hw/rtl/fir_decimate_by6_to_int16.sv]
// ----------------------------------------------------------------------------
// fir_decimate_by6_to_int16: 97-tap lowpass FIR decimator, 48 kHz to 8 kHz
// A chain of sample cells forms the delay line; on every DECIMATION-th
// sample the chain is rotated once round past a single multiplier to form
// the FIR sum, which is halved, truncated toward zero and saturated to int16.
// A bypass mode returns every sample halved.
//
//   Port    Dir  Handshake    Payload
//   in_i    in   valid/ready  sample_in  (Q15, signed 16 bits)
//   out_o   out  valid/ready  sample_out (int16, signed 16 bits)
//   cfg     in   cfg_we_i     cfg_wdata_i = bypass_mode (1 bit)
//
// A sample that completes no output leaves the input ready for the next one.
// The sample that completes an output holds the input while the chain rotates
// once past the one multiplier through all TAP_COUNT taps (ST_MAC), then
// through the drain, scale and hand-over states. A bypassed item goes straight
// to the hand-over state. Reset clears the delay line, phase and mode at once.
// One finished result may wait in the output register while the next item is
// taken; a stalled output holds the block before it starts the next hand-over.
// ----------------------------------------------------------------------------
module fir_decimate_by6_to_int16 #(
  parameter int TAP_COUNT  = fdi_pkg::TAP_COUNT_DEF,
  parameter int DECIMATION = fdi_pkg::DECIMATION_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdi_in_if.sink     in_i,
  fdi_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  localparam int TAP_W   = $clog2(TAP_COUNT);
  localparam int PHASE_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam logic [TAP_W-1:0]   LAST_TAP   = TAP_W'(TAP_COUNT - 1);
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(DECIMATION - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SCALE,
    ST_OUT
  } state_e;

  state_e                               state_q;
  logic                                 bypass_q;
  logic [PHASE_W-1:0]                   phase_q;
  logic [TAP_W-1:0]                     tap_idx_q;
  logic signed [fdi_pkg::SAMPLE_W-1:0]  res_q;
  logic                                 out_vld_q;
  logic signed [fdi_pkg::SAMPLE_W-1:0]  out_data_q;

  logic                                 in_acc;
  logic                                 shift_en;
  logic                                 rot_en;
  logic                                 phase_last;
  logic                                 out_load;
  logic signed [fdi_pkg::SAMPLE_W-1:0]  chain_in;
  logic signed [fdi_pkg::SAMPLE_W-1:0]  taps [TAP_COUNT];
  logic [fdi_pkg::SAMPLE_W-1:0]         byp_sum;
  logic signed [fdi_pkg::SAMPLE_W-1:0]  byp_half;
  logic signed [fdi_pkg::SAMPLE_W-1:0]  mac_result;
  fdi_pkg::mac_ctrl_t                   mac_ctrl;

  // Handshake and chain control.
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign shift_en    = in_acc && !bypass_q;
  assign rot_en      = (state_q == ST_MAC);
  assign phase_last  = (phase_q == LAST_PHASE);
  assign chain_in    = shift_en ? in_i.sample_in : taps[TAP_COUNT-1];

  // A finished result enters the output register once the previous item has gone.
  assign out_load    = (state_q == ST_OUT) && (!out_vld_q || out_o.ready);

  assign mac_ctrl.clear  = shift_en && phase_last;
  assign mac_ctrl.mul_en = rot_en;

  // Halve toward zero for bypass.
  assign byp_sum  = in_i.sample_in + fdi_pkg::SAMPLE_W'(in_i.sample_in[fdi_pkg::SAMPLE_W-1]);
  assign byp_half = $signed(byp_sum) >>> 1;

  // Delay line: new samples enter cell 0; rotation feeds the last cell back.
  for (genvar g = 0; g < TAP_COUNT; g++) begin : g_cell
    fdi_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (shift_en || rot_en),
      .d_i    ((g == 0) ? chain_in : taps[(g == 0) ? 0 : g - 1]),
      .q_o    (taps[g])
    );
  end

  fdi_mac #(
    .TAP_COUNT (TAP_COUNT)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (taps[TAP_COUNT-1]),
    .coef_i   (fdi_pkg::coef_at(fdi_pkg::IDX_W'(tap_idx_q))),
    .result_o (mac_result)
  );

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b0;
    end else if (cfg_we_i) begin
      bypass_q <= cfg_wdata_i;
    end
  end

  // Sequencer, phase count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= '0;
      tap_idx_q  <= '0;
      res_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (out_load) begin
        out_vld_q  <= 1'b1;
        out_data_q <= res_q;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (bypass_q) begin
              res_q   <= byp_half;
              state_q <= ST_OUT;
            end else if (phase_last) begin
              phase_q   <= '0;
              tap_idx_q <= LAST_TAP;
              state_q   <= ST_MAC;
            end else begin
              phase_q <= phase_q + PHASE_W'(1);
            end
          end
        end
        ST_MAC: begin
          tap_idx_q <= tap_idx_q - TAP_W'(1);
          if (tap_idx_q == '0) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          res_q   <= mac_result;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_data_q;

endmodule
